@@ sv/lvwd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the variable-width LZW decoder: constants, codes and the
// command and status structs between controller and datapath. No dependencies.
package lvwd_pkg;

  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int CODE_W = 12;
  localparam int STORE_W = 20;
  localparam int HELD_W = 5;
  localparam int STEP_W = 7;
  localparam int MAX_OUT = 64;
  localparam int LITERALS = 256;
  localparam logic [CODE_W-1:0] CODE_END = 12'd4094;
  localparam logic [CODE_W-1:0] CODE_RESTART = 12'd4095;
  localparam logic [3:0] WIDTH_MIN = 4'd9;
  localparam logic [3:0] WIDTH_10 = 4'd10;
  localparam logic [3:0] WIDTH_11 = 4'd11;
  localparam logic [3:0] WIDTH_12 = 4'd12;
  localparam int GROW_10 = 512;
  localparam int GROW_11 = 1024;
  localparam int GROW_12 = 2048;

  typedef enum logic [1:0] {
    PH_AWAIT = 2'd0,
    PH_RUN   = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PUSH_CODE     = 2'd0,
    PUSH_PREVHEAD = 2'd1,
    PUSH_SUFFIX   = 2'd2,
    PUSH_LIT      = 2'd3
  } push_sel_t;

  typedef enum logic [1:0] {
    LIT_CODE   = 2'd0,
    LIT_PREV   = 2'd1,
    LIT_PREFIX = 2'd2
  } lit_sel_t;

  typedef enum logic [1:0] {
    RD_CODE   = 2'd0,
    RD_PREV   = 2'd1,
    RD_PREFIX = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    FIRST_CODE     = 2'd0,
    FIRST_PREVHEAD = 2'd1,
    FIRST_MEM      = 2'd2
  } first_sel_t;

  typedef struct packed {
    logic       restart;
    logic       load_byte;
    logic       phase_we;
    phase_t     phase_val;
    logic       push_en;
    push_sel_t  push_sel;
    logic       lit_we;
    lit_sel_t   lit_sel;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       first_we;
    first_sel_t first_sel;
    logic       set_prev_code;
    logic       add_entry;
    logic       step_clr;
    logic       stk_read;
    logic       out_data;
    logic       out_stat;
    status_t    stat_val;
  } dp_cmd_t;

  typedef struct packed {
    logic   code_ready;
    phase_t phase;
    logic   code_lt256;
    logic   code_is_end;
    logic   code_is_restart;
    logic   code_lt_nf;
    logic   code_eq_nf;
    logic   nf_full;
    logic   prev_lt256;
    logic   prefix_lt256;
    logic   sp_zero;
    logic   step_full;
    logic   out_free;
  } dp_stat_t;

endpackage

@@ sv/lvwd_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the LZW decoder: compressed input and decoded output.
// Depends on nothing.
interface lvwd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface lvwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;
  modport source (output valid, out_byte, byte_valid, status, last, input ready);
  modport sink (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

@@ sv/lzw_variable_width_decoder_top.sv @@
`timescale 1ns / 1ps
// Variable-width LZW decoder (9 to 12 bit codes). A byte that completes no
// code is only taken in; a code is decoded and walks the dictionary where
// needed, then each decoded byte goes through the registered reverse stack
// read to the output, waiting while the output stalls. At most 64 bytes
// leave per input item. Reset is synchronous and starts a new stream; the
// tables need no clearing pass. Depends on lvwd_pkg, lvwd_if, lvwd_ctrl, lvwd_datapath.
module lzw_variable_width_decoder_top import lvwd_pkg::*; #(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input logic clk,
  input logic rst,
  lvwd_in_if.sink in_ch,
  lvwd_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lvwd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lvwd_datapath #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (in_ch.data_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .status     (out_ch.status),
    .last       (out_ch.last)
  );

endmodule

@@ sv/lvwd_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the LZW decoder: bit unpacker, dictionary memories, reverse
// stack and output register. Depends on lvwd_pkg.
module lvwd_datapath import lvwd_pkg::*; #(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int NW = AW + 1;

  logic [STORE_W-1:0] bit_store;
  logic [HELD_W-1:0]  bits_held;
  logic [3:0]         code_width;
  logic [NW-1:0]      next_free;
  logic [AW-1:0]      prior_code;
  logic [7:0]         prev_head;
  phase_t             phase;
  logic [CODE_W-1:0]  code;
  logic [7:0]         lit;
  logic [7:0]         first;
  logic [NW-1:0]      sp;
  logic [STEP_W-1:0]  step;

  logic [AW-1:0] prefix_mem [DICT_ENTRIES];
  logic [7:0]    suffix_mem [DICT_ENTRIES];
  logic [7:0]    fchar_mem [DICT_ENTRIES];
  logic [7:0]    stack_mem [DICT_ENTRIES];
  logic [AW-1:0] prefix_rd;
  logic [7:0]    suffix_rd;
  logic [7:0]    fchar_rd;
  logic [7:0]    stk_rd;

  logic [STORE_W-1:0] store_cat;
  logic [HELD_W-1:0]  held_cat;
  logic [HELD_W-1:0]  shift;
  logic [STORE_W-1:0] code_mask;
  logic [STORE_W-1:0] rem_mask;
  logic [CODE_W-1:0]  new_code;
  logic [NW-1:0]      nf_inc;
  logic [3:0]         width_next;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         push_data;
  logic [7:0]         lit_data;
  logic [7:0]         first_data;
  logic               push_ok;
  logic               entry_ok;

  assign store_cat = {bit_store[STORE_W-9:0], data_byte};
  assign held_cat  = bits_held + HELD_W'(8);
  assign shift     = held_cat - HELD_W'(code_width);
  assign code_mask = (STORE_W'(1) << code_width) - STORE_W'(1);
  assign rem_mask  = (STORE_W'(1) << shift) - STORE_W'(1);
  assign new_code  = CODE_W'((store_cat >> shift) & code_mask);
  assign nf_inc    = next_free + NW'(1);
  assign push_ok   = cmd.push_en && (sp < NW'(DICT_ENTRIES));
  assign entry_ok  = cmd.add_entry && !stat.nf_full;

  always_comb begin
    if (32'(nf_inc) >= GROW_12) begin
      width_next = WIDTH_12;
    end else if (32'(nf_inc) >= GROW_11) begin
      width_next = WIDTH_11;
    end else if (32'(nf_inc) >= GROW_10) begin
      width_next = WIDTH_10;
    end else begin
      width_next = code_width;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_CODE:   rd_addr = code[AW-1:0];
      RD_PREV:   rd_addr = prior_code;
      RD_PREFIX: rd_addr = prefix_rd;
      default:   rd_addr = code[AW-1:0];
    endcase
    case (cmd.push_sel)
      PUSH_CODE:     push_data = code[7:0];
      PUSH_PREVHEAD: push_data = prev_head;
      PUSH_SUFFIX:   push_data = suffix_rd;
      PUSH_LIT:      push_data = lit;
      default:       push_data = lit;
    endcase
    case (cmd.lit_sel)
      LIT_CODE:   lit_data = code[7:0];
      LIT_PREV:   lit_data = prior_code[7:0];
      LIT_PREFIX: lit_data = prefix_rd[7:0];
      default:    lit_data = code[7:0];
    endcase
    case (cmd.first_sel)
      FIRST_CODE:     first_data = code[7:0];
      FIRST_PREVHEAD: first_data = prev_head;
      FIRST_MEM:      first_data = fchar_rd;
      default:        first_data = code[7:0];
    endcase
  end

  always_comb begin
    stat.code_ready      = held_cat >= HELD_W'(code_width);
    stat.phase           = phase;
    stat.code_lt256      = code < CODE_W'(LITERALS);
    stat.code_is_end     = code == CODE_END;
    stat.code_is_restart = code == CODE_RESTART;
    stat.code_lt_nf      = 13'(code) < 13'(next_free);
    stat.code_eq_nf      = 13'(code) == 13'(next_free);
    stat.nf_full         = next_free >= NW'(DICT_ENTRIES);
    stat.prev_lt256      = prior_code < AW'(LITERALS);
    stat.prefix_lt256    = prefix_rd < AW'(LITERALS);
    stat.sp_zero         = sp == '0;
    stat.step_full       = step == STEP_W'(MAX_OUT);
    stat.out_free        = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      bit_store  <= '0;
      bits_held  <= '0;
      code_width <= WIDTH_MIN;
      next_free  <= NW'(LITERALS);
      prior_code <= '0;
      prev_head  <= '0;
      phase      <= PH_AWAIT;
      sp         <= '0;
      step       <= '0;
    end else begin
      if (cmd.load_byte) begin
        if (stat.code_ready) begin
          bits_held <= shift;
          bit_store <= store_cat & rem_mask;
        end else begin
          bits_held <= held_cat;
          bit_store <= store_cat;
        end
      end
      if (cmd.phase_we) begin
        phase <= cmd.phase_val;
      end
      if (cmd.set_prev_code) begin
        prior_code <= code[AW-1:0];
        prev_head  <= code[7:0];
      end
      if (cmd.add_entry) begin
        prior_code <= code[AW-1:0];
        prev_head  <= first;
        if (entry_ok) begin
          next_free  <= nf_inc;
          code_width <= width_next;
        end
      end
      if (push_ok) begin
        sp <= sp + NW'(1);
      end else if (cmd.stk_read) begin
        sp <= sp - NW'(1);
      end
      if (cmd.step_clr) begin
        step <= '0;
      end else if (cmd.stk_read) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte && stat.code_ready) begin
      code <= new_code;
    end
    if (cmd.lit_we) begin
      lit <= lit_data;
    end
    if (cmd.first_we) begin
      first <= first_data;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_ok) begin
      prefix_mem[next_free[AW-1:0]] <= prior_code;
      suffix_mem[next_free[AW-1:0]] <= first;
      fchar_mem[next_free[AW-1:0]]  <= prev_head;
    end
    if (cmd.rd_en) begin
      prefix_rd <= prefix_mem[rd_addr];
      suffix_rd <= suffix_mem[rd_addr];
      fchar_rd  <= fchar_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[sp[AW-1:0]] <= push_data;
    end
    if (cmd.stk_read) begin
      stk_rd <= stack_mem[AW'(sp - NW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_data || cmd.out_stat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_data) begin
      out_byte   <= stk_rd;
      byte_valid <= 1'b1;
      status     <= ST_DATA;
      last       <= stat.sp_zero;
    end else if (cmd.out_stat) begin
      out_byte   <= '0;
      byte_valid <= 1'b0;
      status     <= cmd.stat_val;
      last       <= 1'b1;
    end
  end

endmodule

@@ sv/lvwd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the LZW decoder: sequences unpacking, table walk, dictionary
// update and draining of the reverse stack. Depends on lvwd_pkg.
module lvwd_ctrl import lvwd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_TAIL   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_STAT   = 7'b1000000
  } state_t;

  state_t  state;
  state_t  state_next;
  logic    walk_first;
  logic    walk_first_next;
  status_t stat_sel;
  status_t stat_sel_next;
  logic    in_fire;

  assign in_ready = state == S_IDLE;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    walk_first_next = walk_first;
    stat_sel_next   = stat_sel;
    cmd.stat_val    = stat_sel;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command) begin
            cmd.restart = 1'b1;
          end else if (!stat.sp_zero) begin
            cmd.step_clr = 1'b1;
            state_next   = S_DRAIN;
          end else if (stat.phase != PH_STOP) begin
            cmd.load_byte = 1'b1;
            if (stat.code_ready) begin
              state_next = S_DECODE;
            end
          end
        end
      end
      S_DECODE: begin
        if (stat.phase == PH_AWAIT) begin
          if (!stat.code_lt256) begin
            cmd.phase_we  = 1'b1;
            cmd.phase_val = PH_STOP;
            stat_sel_next = ST_ERR;
            state_next    = S_STAT;
          end else begin
            cmd.push_en       = 1'b1;
            cmd.push_sel      = PUSH_CODE;
            cmd.set_prev_code = 1'b1;
            cmd.phase_we      = 1'b1;
            cmd.phase_val     = PH_RUN;
            cmd.step_clr      = 1'b1;
            state_next        = S_DRAIN;
          end
        end else if (stat.code_is_end) begin
          cmd.phase_we  = 1'b1;
          cmd.phase_val = PH_STOP;
          stat_sel_next = ST_END;
          state_next    = S_STAT;
        end else if (stat.code_is_restart) begin
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end else if (stat.code_lt_nf) begin
          if (stat.code_lt256) begin
            cmd.lit_we    = 1'b1;
            cmd.lit_sel   = LIT_CODE;
            cmd.first_we  = 1'b1;
            cmd.first_sel = FIRST_CODE;
            state_next    = S_TAIL;
          end else begin
            cmd.rd_en       = 1'b1;
            cmd.rd_sel      = RD_CODE;
            walk_first_next = 1'b1;
            state_next      = S_WALK;
          end
        end else if (stat.code_eq_nf && !stat.nf_full) begin
          cmd.push_en   = 1'b1;
          cmd.push_sel  = PUSH_PREVHEAD;
          cmd.first_we  = 1'b1;
          cmd.first_sel = FIRST_PREVHEAD;
          if (stat.prev_lt256) begin
            cmd.lit_we  = 1'b1;
            cmd.lit_sel = LIT_PREV;
            state_next  = S_TAIL;
          end else begin
            cmd.rd_en       = 1'b1;
            cmd.rd_sel      = RD_PREV;
            walk_first_next = 1'b0;
            state_next      = S_WALK;
          end
        end else begin
          cmd.phase_we  = 1'b1;
          cmd.phase_val = PH_STOP;
          stat_sel_next = ST_ERR;
          state_next    = S_STAT;
        end
      end
      S_WALK: begin
        cmd.push_en     = 1'b1;
        cmd.push_sel    = PUSH_SUFFIX;
        cmd.first_we    = walk_first;
        cmd.first_sel   = FIRST_MEM;
        walk_first_next = 1'b0;
        if (stat.prefix_lt256) begin
          cmd.lit_we  = 1'b1;
          cmd.lit_sel = LIT_PREFIX;
          state_next  = S_TAIL;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREFIX;
        end
      end
      S_TAIL: begin
        cmd.push_en   = 1'b1;
        cmd.push_sel  = PUSH_LIT;
        cmd.add_entry = 1'b1;
        cmd.step_clr  = 1'b1;
        state_next    = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.stk_read = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_data = 1'b1;
          if (stat.sp_zero || stat.step_full) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_DRAIN;
          end
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.out_stat = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_first <= 1'b0;
      stat_sel   <= ST_DATA;
    end else begin
      state      <= state_next;
      walk_first <= walk_first_next;
      stat_sel   <= stat_sel_next;
    end
  end

endmodule
